// File: rtl/core/wmft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmft_pkg
// Field widths and request/response codes of the window max frequency
// tracker.
// ----------------------------------------------------------------------------
package wmft_pkg;

   localparam int CMD_W    = 1;
   localparam int VALUE_W  = 10;
   localparam int FREQ_W   = 11;
   localparam int STATUS_W = 2;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [FREQ_W-1:0]   freq_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_ADD    = 1'b0;
   localparam cmd_type CMD_REMOVE = 1'b1;

   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_ABSENT = 2'd1;
   localparam status_type STATUS_LIMIT  = 2'd2;

endpackage
`default_nettype wire

// File: rtl/core/window_max_frequency_tracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_max_frequency_tracker_core
// Keeps per-value occurrence counts of a window and reports the largest one.
//
// A request (req_cmd, req_item_value) is taken on a clock edge where start is
// high and busy is low: req_cmd adds the value to the window or removes it.
// Every request gives exactly one response: rsp_strobe is high for one cycle
// with the maximum count after the step on rsp_max_frequency and a status
// (ok, removal of an absent value, count already at MAX_COUNT). Rejected
// requests change nothing.
// A request passes through S_READ_COUNT, S_WRITE_INC and S_WRITE_DEC from
// acceptance until busy drops again (only S_READ_COUNT when it is rejected),
// and a new request is taken only once the last one is through; the response
// appears in the cycle busy drops, so the next request can be taken while it
// is shown. The states come from the read-modify-write of the count memory
// and the two writes to the single write port of the count-of-counts memory.
// After reset both memories are zeroed by a clearing pass over
// max(2**VALUE_BITS, MAX_COUNT) addresses, during which busy is high.
// The receiver cannot stall: each response is valid for that one cycle only.
// ----------------------------------------------------------------------------
module window_max_frequency_tracker_core #(
   parameter int VALUE_BITS = 10,
   parameter int MAX_COUNT  = 1024
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire wmft_pkg::cmd_type   req_cmd,
   input  wire wmft_pkg::value_type req_item_value,
   output logic                    rsp_strobe,
   output wmft_pkg::freq_type      rsp_max_frequency,
   output wmft_pkg::status_type    rsp_status
);

   import wmft_pkg::*;

   localparam int NUM_VALUES = 1 << VALUE_BITS;
   localparam int CNT_W      = $clog2(MAX_COUNT + 1);
   localparam int COC_AW     = $clog2(MAX_COUNT);
   localparam int OCC_W      = VALUE_BITS + 1;
   localparam int CLR_LEN    = (NUM_VALUES > MAX_COUNT) ? NUM_VALUES : MAX_COUNT;
   localparam int CLR_W      = $clog2(CLR_LEN);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ_COUNT,
      S_WRITE_INC,
      S_WRITE_DEC
   } state_type;

   state_type                state_ff;
   logic [CLR_W-1:0]         clr_ff;
   cmd_type                  cmd_ff;
   logic [VALUE_BITS-1:0]    idx_ff;
   logic [CNT_W-1:0]         old_ff;
   logic [CNT_W-1:0]         max_ff;
   logic                     rsp_strobe_ff;
   freq_type                 rsp_freq_ff;
   status_type               rsp_status_ff;

   // memories
   logic [CNT_W-1:0]         vc_mem_ff [NUM_VALUES];
   logic [OCC_W-1:0]         coc_mem_ff [MAX_COUNT];
   logic [CNT_W-1:0]         vc_rdata_ff;
   logic [OCC_W-1:0]         occ_dec_ff;
   logic [OCC_W-1:0]         occ_inc_ff;

   logic                     accept;
   logic [VALUE_BITS-1:0]    req_idx;
   logic [VALUE_BITS-1:0]    vc_raddr;
   logic                     vc_we;
   logic [VALUE_BITS-1:0]    vc_waddr;
   logic [CNT_W-1:0]         vc_wdata;
   logic                     coc_re;
   logic [COC_AW-1:0]        coc_raddr_dec;
   logic [COC_AW-1:0]        coc_raddr_inc;
   logic                     coc_we;
   logic [COC_AW-1:0]        coc_waddr;
   logic [OCC_W-1:0]         coc_wdata;
   logic                     clr_in_vc;
   logic                     clr_in_coc;
   logic                     clr_last;
   logic                     rd_is_add;
   logic                     rd_limit;
   logic                     rd_absent;
   logic                     inc_en;
   logic                     dec_en;
   logic [CNT_W-1:0]         new_cnt;
   logic [OCC_W-1:0]         occ_dec_next;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign req_idx = VALUE_BITS'(req_item_value);

   assign clr_in_vc  = ({1'b0, clr_ff} < (CLR_W + 1)'(NUM_VALUES));
   assign clr_in_coc = ({1'b0, clr_ff} < (CLR_W + 1)'(MAX_COUNT));
   assign clr_last   = (clr_ff == CLR_W'(CLR_LEN - 1));

   // decode of the count just read
   assign rd_is_add = (cmd_ff == CMD_ADD);
   assign rd_limit  = rd_is_add && (vc_rdata_ff >= CNT_W'(MAX_COUNT));
   assign rd_absent = !rd_is_add && (vc_rdata_ff == '0);
   assign new_cnt   = rd_is_add ? (vc_rdata_ff + CNT_W'(1)) : (vc_rdata_ff - CNT_W'(1));

   // occupancy entry of the old count, and of the count the value moves to
   assign coc_raddr_dec = (vc_rdata_ff != '0) ? COC_AW'(vc_rdata_ff - CNT_W'(1)) : '0;
   always_comb begin
      if (rd_is_add) begin
         coc_raddr_inc = COC_AW'(vc_rdata_ff);
      end else if (vc_rdata_ff >= CNT_W'(2)) begin
         coc_raddr_inc = COC_AW'(vc_rdata_ff - CNT_W'(2));
      end else begin
         coc_raddr_inc = '0;
      end
   end

   assign inc_en       = (cmd_ff == CMD_ADD) || (old_ff >= CNT_W'(2));
   assign dec_en       = (old_ff != '0);
   assign occ_dec_next = occ_dec_ff - ((occ_dec_ff != '0) ? OCC_W'(1) : OCC_W'(0));

   assign vc_raddr = req_idx;
   assign coc_re   = (state_ff == S_READ_COUNT);

   always_comb begin
      vc_we     = 1'b0;
      vc_waddr  = idx_ff;
      vc_wdata  = new_cnt;
      coc_we    = 1'b0;
      coc_waddr = COC_AW'(old_ff);
      coc_wdata = occ_inc_ff + OCC_W'(1);
      case (state_ff)
         S_CLEAR: begin
            vc_we     = clr_in_vc;
            vc_waddr  = clr_ff[VALUE_BITS-1:0];
            vc_wdata  = '0;
            coc_we    = clr_in_coc;
            coc_waddr = clr_ff[COC_AW-1:0];
            coc_wdata = '0;
         end
         S_READ_COUNT: begin
            vc_we = !rd_limit && !rd_absent;
         end
         S_WRITE_INC: begin
            coc_we = inc_en;
            if (cmd_ff == CMD_ADD) begin
               coc_waddr = COC_AW'(old_ff);
            end else begin
               coc_waddr = COC_AW'(old_ff - CNT_W'(2));
            end
            coc_wdata = occ_inc_ff + OCC_W'(1);
         end
         S_WRITE_DEC: begin
            coc_we    = dec_en;
            coc_waddr = COC_AW'(old_ff - CNT_W'(1));
            coc_wdata = occ_dec_next;
         end
         default: begin
            vc_we  = 1'b0;
            coc_we = 1'b0;
         end
      endcase
   end

   // value count memory: one read, one write port
   always_ff @(posedge clock) begin
      if (vc_we) begin
         vc_mem_ff[vc_waddr] <= vc_wdata;
      end
      vc_rdata_ff <= vc_mem_ff[vc_raddr];
   end

   // count-of-counts memory: two read, one write port
   always_ff @(posedge clock) begin
      if (coc_we) begin
         coc_mem_ff[coc_waddr] <= coc_wdata;
      end
      if (coc_re) begin
         occ_dec_ff <= coc_mem_ff[coc_raddr_dec];
         occ_inc_ff <= coc_mem_ff[coc_raddr_inc];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         max_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CLR_W'(1);
               if (clr_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req_cmd;
                  idx_ff   <= req_idx;
                  state_ff <= S_READ_COUNT;
               end
            end
            S_READ_COUNT: begin
               old_ff <= vc_rdata_ff;
               if (rd_limit || rd_absent) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_freq_ff   <= FREQ_W'(max_ff);
                  rsp_status_ff <= rd_limit ? STATUS_LIMIT : STATUS_ABSENT;
                  state_ff      <= S_IDLE;
               end else begin
                  state_ff <= S_WRITE_INC;
               end
            end
            S_WRITE_INC: begin
               if ((cmd_ff == CMD_ADD) && ((old_ff + CNT_W'(1)) > max_ff)) begin
                  max_ff <= old_ff + CNT_W'(1);
               end
               state_ff <= S_WRITE_DEC;
            end
            S_WRITE_DEC: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= STATUS_OK;
               // removal empties the top count bucket
               if ((cmd_ff == CMD_REMOVE) && (max_ff == old_ff) && (occ_dec_next == '0)) begin
                  max_ff      <= max_ff - CNT_W'(1);
                  rsp_freq_ff <= FREQ_W'(max_ff - CNT_W'(1));
               end else begin
                  rsp_freq_ff <= FREQ_W'(max_ff);
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_max_frequency = rsp_freq_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
`default_nettype wire
